/* rtl/text_console_writer_unit_defines.svh */
// assertion macros shared by the console checker
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

// property checked outside reset
`define CTW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define CTW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/ctw_pkg.sv */
// shared constants and types for the text console writer
`timescale 1ns / 1ps
`default_nettype none

package ctw_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // fixed field widths
  localparam int KIND_W = 2;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 11;
  localparam int OFS_W  = 11;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_PRINT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // control characters
  localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
  localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;

  // attribute after reset: white on black
  localparam logic [BYTE_W-1:0] ATTR_RESET = 8'h0F;

  // store access command from the controller
  typedef struct packed {
    logic wr_char;
    logic wr_attr;
    logic rd;
  } store_cmd_t;

endpackage

`default_nettype wire

/* rtl/ctw_store.sv */
// cell store: character and attribute memories, one write and one read port
`timescale 1ns / 1ps
`default_nettype none

module ctw_store
  import ctw_pkg::*;
#(
  parameter int CELLS = COLUMNS_DEF * ROWS_DEF,
  localparam int AW   = $clog2(CELLS)
) (
  input  wire              clk,
  input  store_cmd_t       cmd,
  input  wire [AW-1:0]     waddr,
  input  wire [BYTE_W-1:0] wchar,
  input  wire [BYTE_W-1:0] wattr,
  input  wire [AW-1:0]     raddr,
  output logic [BYTE_W-1:0] rchar,
  output logic [BYTE_W-1:0] rattr
);

  logic [BYTE_W-1:0] char_mem [CELLS];
  logic [BYTE_W-1:0] attr_mem [CELLS];

  // character byte lane
  always_ff @(posedge clk) begin
    if (cmd.wr_char) begin
      char_mem[waddr] <= wchar;
    end
    if (cmd.rd) begin
      rchar <= char_mem[raddr];
    end
  end

  // attribute byte lane
  always_ff @(posedge clk) begin
    if (cmd.wr_attr) begin
      attr_mem[waddr] <= wattr;
    end
    if (cmd.rd) begin
      rattr <= attr_mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/ctw_ctrl.sv */
// request sequencer: cursor, attribute register, scroll and clear sweeps
`timescale 1ns / 1ps
`default_nettype none

module ctw_ctrl
  import ctw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF,
  localparam int CELLS  = COLUMNS * ROWS,
  localparam int AW     = $clog2(CELLS)
) (
  input  wire               clk,
  input  wire               rst,
  // configuration
  input  wire               cfg_we,
  input  wire [BYTE_W-1:0]  cfg_data,
  // request word
  input  wire               in_valid,
  output logic              in_ready,
  input  wire [KIND_W-1:0]  kind,
  input  wire [BYTE_W-1:0]  char_code,
  input  wire [IDX_W-1:0]   cell_index,
  // result word
  output logic              res_valid,
  input  wire               res_ready,
  output logic [OFS_W-1:0]  res_offset,
  output logic [BYTE_W-1:0] res_char,
  output logic [BYTE_W-1:0] res_attr,
  // store port
  output store_cmd_t        cmd,
  output logic [AW-1:0]     waddr,
  output logic [BYTE_W-1:0] wchar,
  output logic [BYTE_W-1:0] wattr,
  output logic [AW-1:0]     raddr,
  input  wire [BYTE_W-1:0]  rchar,
  input  wire [BYTE_W-1:0]  rattr
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int COPY  = (ROWS - 2) * COLUMNS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_COPY = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state;
  logic [CNT_W-1:0]  cnt;
  logic              reply;
  logic              hit;
  logic [CW-1:0]     col;
  logic [RW-1:0]     row;
  logic [BYTE_W-1:0] attr;

  logic              accept;
  logic [AW-1:0]     pos;
  logic [CW:0]       col_t;
  logic [CW:0]       tab_sum;
  logic [RW:0]       row_t;
  logic [RW:0]       row_a;
  logic              wrap;
  logic              scroll;
  logic [CW-1:0]     col_next;
  logic [RW-1:0]     row_next;
  logic              pr_wc;
  logic              pr_wa;
  logic [AW-1:0]     pr_addr;

  assign accept = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  // linear cursor position
  assign pos = AW'(row) * AW'(COLUMNS) + AW'(col);

  // result fields
  assign res_offset = OFS_W'(pos);
  assign res_char   = hit ? rchar : '0;
  assign res_attr   = hit ? rattr : '0;

  // attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
    end else if (cfg_we) begin
      attr <= cfg_data;
    end
  end

  // printed character: cursor move and cell write
  always_comb begin
    tab_sum = (CW+1)'(col) + (CW+1)'(8);
    col_t   = {1'b0, col};
    row_t   = {1'b0, row};
    pr_wc   = 1'b0;
    pr_wa   = 1'b0;
    pr_addr = pos;
    case (char_code)
      CH_BS: begin
        if (col != '0) begin
          col_t   = {1'b0, col} - (CW+1)'(1);
          pr_wc   = 1'b1;
          pr_addr = pos - AW'(1);
        end
      end
      CH_TAB: begin
        col_t = {tab_sum[CW:3], 3'b000};
      end
      CH_CR: begin
        col_t = '0;
      end
      CH_LF: begin
        col_t = '0;
        row_t = {1'b0, row} + (RW+1)'(1);
      end
      default: begin
        pr_wc = 1'b1;
        pr_wa = 1'b1;
        col_t = {1'b0, col} + (CW+1)'(1);
      end
    endcase
    wrap     = (col_t >= (CW+1)'(COLUMNS));
    row_a    = wrap ? row_t + (RW+1)'(1) : row_t;
    col_next = wrap ? '0 : col_t[CW-1:0];
    scroll   = (row_a >= (RW+1)'(ROWS - 1));
    row_next = scroll ? RW'(ROWS - 2) : row_a[RW-1:0];
  end

  // store port drive
  always_comb begin
    cmd   = '0;
    waddr = pr_addr;
    wchar = '0;
    wattr = '0;
    raddr = AW'(cell_index);
    case (state)
      ST_IDLE: begin
        if (accept && kind == KIND_PRINT) begin
          cmd.wr_char = pr_wc;
          cmd.wr_attr = pr_wa;
          wchar       = (char_code == CH_BS) ? '0 : char_code;
          wattr       = attr;
        end
        cmd.rd = accept && (kind == KIND_READ);
      end
      ST_COPY: begin
        // read one row below, write back the word read last cycle
        cmd.rd      = (cnt != CNT_W'(COPY));
        raddr       = AW'(cnt + CNT_W'(COLUMNS));
        cmd.wr_char = (cnt != '0);
        cmd.wr_attr = (cnt != '0);
        waddr       = AW'(cnt - CNT_W'(1));
        wchar       = rchar;
        wattr       = rattr;
      end
      ST_ZERO: begin
        cmd.wr_char = 1'b1;
        cmd.wr_attr = 1'b1;
        waddr       = AW'(cnt);
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ZERO;
      cnt   <= '0;
      reply <= 1'b0;
      hit   <= 1'b0;
      col   <= '0;
      row   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            hit <= (kind == KIND_READ) && (32'(cell_index) < CELLS);
            cnt <= '0;
            if (kind == KIND_PRINT) begin
              col   <= col_next;
              row   <= row_next;
              state <= scroll ? ST_COPY : ST_DONE;
            end else if (kind == KIND_CLEAR) begin
              col   <= '0;
              row   <= '0;
              reply <= 1'b1;
              state <= ST_ZERO;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_COPY: begin
          if (cnt == CNT_W'(COPY)) begin
            reply <= 1'b1;
            state <= ST_ZERO;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_ZERO: begin
          if (cnt == CNT_W'(CELLS - 1)) begin
            state <= reply ? ST_DONE : ST_IDLE;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/text_console_writer_unit.sv */
// Text-mode console, COLUMNS x ROWS cells of character and attribute bytes
// plus a cursor. After reset a clearing pass writes every cell to zero before
// the first word is taken. One request word is worked on at a time. A read,
// an unused kind, or a printed byte that does not scroll passes from the done
// state into the output register once that register is free, and the block
// takes the next word from that same cycle on, so no new word is taken before
// the last result has been handed on. The cell store read is registered. A
// scroll sweeps the store through its one read and one write port, copying
// each row up by one and then blanking the bottom two rows. A clear blanks
// every cell. The result sits in an output register, so the next word is
// taken while it waits.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_unit
  import ctw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               cfg_we,
  input  wire [BYTE_W-1:0]  cfg_data,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire [KIND_W-1:0]  kind,
  input  wire [BYTE_W-1:0]  char_code,
  input  wire [IDX_W-1:0]   cell_index,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [OFS_W-1:0]  cursor_offset,
  output logic [BYTE_W-1:0] read_char,
  output logic [BYTE_W-1:0] read_attr
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  store_cmd_t        cmd;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [BYTE_W-1:0] wchar;
  logic [BYTE_W-1:0] wattr;
  logic [BYTE_W-1:0] rchar;
  logic [BYTE_W-1:0] rattr;
  logic              res_valid;
  logic              res_ready;
  logic [OFS_W-1:0]  res_offset;
  logic [BYTE_W-1:0] res_char;
  logic [BYTE_W-1:0] res_attr;

  ctw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .char_code  (char_code),
    .cell_index (cell_index),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_offset (res_offset),
    .res_char   (res_char),
    .res_attr   (res_attr),
    .cmd        (cmd),
    .waddr      (waddr),
    .wchar      (wchar),
    .wattr      (wattr),
    .raddr      (raddr),
    .rchar      (rchar),
    .rattr      (rattr)
  );

  ctw_store #(
    .CELLS (CELLS)
  ) u_store (
    .clk   (clk),
    .cmd   (cmd),
    .waddr (waddr),
    .wchar (wchar),
    .wattr (wattr),
    .raddr (raddr),
    .rchar (rchar),
    .rattr (rattr)
  );

  // output register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      cursor_offset <= res_offset;
      read_char     <= res_char;
      read_attr     <= res_attr;
    end
  end

endmodule

`default_nettype wire

/* rtl/ctw_checker.sv */
// port-level checks for the text console writer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_writer_unit_defines.svh"

module ctw_checker
  import ctw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input wire             clk,
  input wire             rst,
  input wire             in_valid,
  input wire             in_ready,
  input wire             out_valid,
  input wire             out_ready,
  input wire [OFS_W-1:0] cursor_offset
);

  // the cursor never rests on the last row
  localparam int  LIMIT = (ROWS - 1) * COLUMNS;
  localparam bit  WRAPS = (LIMIT > (1 << OFS_W));

  // store is being cleared right after reset
  `CTW_ASSERT_ALWAYS(a_busy_after_reset, rst |=> !in_ready, "ready right after reset")

  // one word at a time
  `CTW_ASSERT(a_one_in_flight, in_valid && in_ready |=> !in_ready, "second word taken early")

  // reported cursor stays above the last row
  `CTW_ASSERT(a_cursor_range, out_valid |-> WRAPS || cursor_offset < LIMIT, "cursor out of range")

  // a stalled result stays offered
  `CTW_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped")

endmodule

bind text_console_writer_unit ctw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_ctw_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .cursor_offset (cursor_offset)
);

`default_nettype wire

/* sim/tb.sv */
// self-checking testbench for the text console writer
`timescale 1ns / 1ps
module tb;
  import ctw_pkg::*;

  localparam int COLS = COLUMNS_DEF;
  localparam int ROWS = ROWS_DEF;
  localparam int CELLS = COLS * ROWS;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_WORDS = 400;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } console_word_t;

  typedef struct packed {
    logic [OFS_W-1:0]  offset;
    logic [BYTE_W-1:0] ch;
    logic [BYTE_W-1:0] attr;
  } console_result_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [BYTE_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] char_code;
  logic [IDX_W-1:0]  cell_index;
  logic              out_valid;
  logic              out_ready;
  logic [OFS_W-1:0]  cursor_offset;
  logic [BYTE_W-1:0] read_char;
  logic [BYTE_W-1:0] read_attr;

  // shadow copy of the screen, cursor and attribute
  logic [15:0]       screen_shadow [0:CELLS-1];
  int                cur_col;
  int                cur_row;
  logic [BYTE_W-1:0] attr_shadow;

  console_word_t   request_words[$];
  console_result_t pending_results[$];
  console_word_t   next_word;
  console_result_t due_result;
  logic            word_taken;

  int words_queued = 0;
  int words_taken = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int scroll_count = 0;
  int clear_count = 0;
  int send_idle_pct;
  int recv_idle_pct;

  text_console_writer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .char_code     (char_code),
    .cell_index    (cell_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cursor_offset (cursor_offset),
    .read_char     (read_char),
    .read_attr     (read_attr)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // advance the shadow console by one request word and give its result
  function automatic console_result_t apply_word(console_word_t w);
    console_result_t r;
    int pos;
    r = '0;
    case (w.kind)
      KIND_PRINT: begin
        pos = cur_row * COLS + cur_col;
        case (w.char_code)
          CH_BS: begin
            // only the character byte is wiped, attribute stays
            if (cur_col > 0) begin
              cur_col--;
              pos = cur_row * COLS + cur_col;
              screen_shadow[pos][7:0] = '0;
            end
          end
          CH_TAB: cur_col = (cur_col + 8) & ~7;
          CH_CR: cur_col = 0;
          CH_LF: begin
            cur_col = 0;
            cur_row++;
          end
          default: begin
            screen_shadow[pos] = {attr_shadow, w.char_code};
            cur_col++;
          end
        endcase
        if (cur_col >= COLS) begin
          cur_col = 0;
          cur_row++;
        end
        // last row reached: shift up one row, blank the bottom two
        if (cur_row >= ROWS - 1) begin
          for (int i = 0; i < (ROWS - 1) * COLS; i++)
            screen_shadow[i] = screen_shadow[i + COLS];
          for (int i = (ROWS - 2) * COLS; i < CELLS; i++)
            screen_shadow[i] = '0;
          if (cur_row == 0) cur_col = 0;
          else cur_row--;
          scroll_count++;
        end
      end
      KIND_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_shadow[i] = '0;
        cur_col = 0;
        cur_row = 0;
        clear_count++;
      end
      KIND_READ: begin
        // cells past the screen read as zero
        if (w.cell_index < CELLS) begin
          r.ch = screen_shadow[w.cell_index][7:0];
          r.attr = screen_shadow[w.cell_index][15:8];
        end
      end
      default: ;
    endcase
    r.offset = OFS_W'(cur_row * COLS + cur_col);
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] expected_val,
                             logic [15:0] actual_val);
    if (actual_val !== expected_val) begin
      mismatch_count++;
      $display("%0t: %s expected %0h got %0h", $time, name, expected_val, actual_val);
    end
  endtask

  task automatic queue_word(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] ch,
                            logic [IDX_W-1:0] idx);
    request_words.push_back({k, ch, idx});
    words_queued++;
  endtask

  // hold off until every word is taken and every result is back
  task automatic wait_idle();
    while (words_taken != words_queued || pending_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_attr(logic [BYTE_W-1:0] value);
    cfg_data <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    attr_shadow = value;
  endtask

  // random traffic in bursts: text runs, line feed runs, reads, clears, unused kinds
  task automatic add_random_words(int count);
    int target;
    int sel;
    int pick;
    logic [BYTE_W-1:0] ch;
    target = words_queued + count;
    while (words_queued < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        repeat ($urandom_range(1, 30)) begin
          pick = $urandom_range(0, 99);
          if (pick < 60) ch = BYTE_W'($urandom_range(8'h20, 8'h7e));
          else if (pick < 78) ch = BYTE_W'($urandom_range(0, 255));
          else begin
            case ($urandom_range(0, 3))
              0: ch = CH_BS;
              1: ch = CH_TAB;
              2: ch = CH_CR;
              default: ch = CH_LF;
            endcase
          end
          queue_word(KIND_PRINT, ch, IDX_W'($urandom_range(0, 2047)));
        end
      end else if (sel < 62) begin
        repeat ($urandom_range(1, 12))
          queue_word(KIND_PRINT, CH_LF, IDX_W'($urandom_range(0, 2047)));
      end else if (sel < 90) begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 99) < 85)
            queue_word(KIND_READ, BYTE_W'($urandom_range(0, 255)),
                       IDX_W'($urandom_range(0, CELLS - 1)));
          else
            queue_word(KIND_READ, BYTE_W'($urandom_range(0, 255)),
                       IDX_W'($urandom_range(CELLS, 2047)));
        end
      end else if (sel < 95) begin
        queue_word(KIND_CLEAR, BYTE_W'($urandom_range(0, 255)),
                   IDX_W'($urandom_range(0, 2047)));
      end else begin
        queue_word(KIND_UNUSED, BYTE_W'($urandom_range(0, 255)),
                   IDX_W'($urandom_range(0, 2047)));
      end
    end
  endtask

  // request side: present the next pending word, with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (request_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_word = request_words.pop_front();
        in_valid <= 1'b1;
        kind <= next_word.kind;
        char_code <= next_word.char_code;
        cell_index <= next_word.cell_index;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side: random stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watch both handshakes
  always @(posedge clk) begin
    if (rst) begin
      word_taken <= 1'b0;
    end else begin
      // compare a result word with the oldest expectation
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result word: offset %0d char %0h attr %0h",
                   $time, cursor_offset, read_char, read_attr);
        end else begin
          due_result = pending_results.pop_front();
          check_field("cursor_offset", 16'(due_result.offset), 16'(cursor_offset));
          check_field("read_char", 16'(due_result.ch), 16'(read_char));
          check_field("read_attr", 16'(due_result.attr), 16'(read_attr));
        end
      end
      // accepted request word: work out its result
      if (in_valid && in_ready) begin
        pending_results.push_back(apply_word({kind, char_code, cell_index}));
        words_taken++;
      end
      word_taken <= in_valid && in_ready;
    end
  end

  // stimulus and phase control
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    kind = '0;
    char_code = '0;
    cell_index = '0;
    out_ready = 1'b0;
    send_idle_pct = 8;
    recv_idle_pct = 67;
    attr_shadow = ATTR_RESET;
    cur_col = 0;
    cur_row = 0;
    for (int i = 0; i < CELLS; i++) screen_shadow[i] = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reads at the edges of the store and past it
    queue_word(KIND_READ, 8'h00, 11'd0);
    queue_word(KIND_READ, 8'hff, 11'(CELLS - 1));
    queue_word(KIND_READ, 8'h00, 11'(CELLS));
    queue_word(KIND_READ, 8'h00, 11'h7ff);
    // printing, backspace keeps the attribute, zero byte prints
    queue_word(KIND_PRINT, 8'h41, 11'h7ff);
    queue_word(KIND_PRINT, 8'hff, 11'd0);
    queue_word(KIND_PRINT, CH_BS, 11'd0);
    queue_word(KIND_READ, 8'h00, 11'd1);
    queue_word(KIND_PRINT, 8'h00, 11'd0);
    queue_word(KIND_READ, 8'h00, 11'd1);
    // backspace at column zero does nothing
    queue_word(KIND_PRINT, CH_CR, 11'd0);
    queue_word(KIND_PRINT, CH_BS, 11'd0);
    queue_word(KIND_PRINT, CH_TAB, 11'd0);
    queue_word(KIND_PRINT, CH_LF, 11'd0);
    queue_word(KIND_UNUSED, 8'hff, 11'h7ff);
    queue_word(KIND_CLEAR, 8'hff, 11'h7ff);
    queue_word(KIND_READ, 8'h00, 11'd0);
    // tabs up to the right edge wrap onto the next row
    repeat (COLS / 8) queue_word(KIND_PRINT, CH_TAB, 11'd0);
    wait_idle();

    write_attr(8'h00);
    add_random_words(PHASE_WORDS);
    wait_idle();

    send_idle_pct = 67;
    recv_idle_pct = 8;
    write_attr(8'hff);
    add_random_words(PHASE_WORDS);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_attr(BYTE_W'($urandom_range(1, 254)));
    add_random_words(PHASE_WORDS);
    wait_idle();

    $display("checked %0d result words from %0d request words over four attribute values",
             results_seen, words_taken);
    $display("the screen scrolled %0d times and was cleared %0d times",
             scroll_count, clear_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100_000_000;
    $display("timeout with %0d of %0d request words taken", words_taken, words_queued);
    $display("Mismatches found");
    $finish;
  end

endmodule
